>>> hdl/mbd_pkg.sv
// mbd_pkg: constants shared by the multi-button debouncer modules
// no dependencies
`default_nettype none

package mbd_pkg;

    localparam int NUM_BUTTONS = 16;

    localparam int IDX_W  = 4;
    localparam int PIN_W  = 1;
    localparam int DT_W   = 8;
    localparam int HOLD_W = 6;
    localparam int CW_W   = 8;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register word index taken from paddr[2]
    localparam logic REG_HOLDOFF = 1'b0;

    localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 6'd20;

    // control word: bit 7 always set, bit 6 down flag, bits 5:0 hold-off count
    localparam logic [CW_W-1:0] CW_UP_READY   = 8'h80;
    localparam logic [CW_W-1:0] CW_DOWN_READY = 8'hC0;
    localparam int              CW_DOWN_BIT   = 6;
    localparam logic [DT_W-1:0] DT_RESYNC_MAX = 8'd128;

    typedef logic [CW_W-2:0] t_cw_store;

endpackage

`default_nettype wire

>>> hdl/multi_button_debouncer.sv
// multi_button_debouncer: per-button debounce with hold-off, state kept in a registered-read memory
// depends on mbd_pkg and mbd_cw_next
//
//  channel   dir   handshake                 content
//  s_*       in    s_tvalid / s_tready       tdata: button_index, pin_level, elapsed_ms
//  m_*       out   m_tvalid / m_tready       tdata: button_id, is_down, is_press
//  apb       in    psel & penable & pwrite   holdoff_ms at byte address 0
//
// one sample per cycle unless stalled by m_tready; results pass the update stage and output register
// the state memory is read on accept and written back when the update stage advances; the
// next sample of the same button reads stale data and takes the forwarded word instead
// synchronous active-low reset clears the valid bits, so every button starts up and ready
// a stall on m_tready holds the output, then the update stage, then s_tready
`default_nettype none

module multi_button_debouncer
    import mbd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // [3:0] button_index, [4] pin_level, [12:5] elapsed_ms, [15:13] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [3:0] button_id, [4] is_down, [5] is_press, [7:6] zero
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready
);

    // configuration
    logic [HOLD_W-1:0] r_holdoff;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff <= HOLDOFF_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_HOLDOFF) begin
            r_holdoff <= pwdata[HOLD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_HOLDOFF) ? {{(APB_DW-HOLD_W){1'b0}}, r_holdoff}
                                              : '0;

    // input fields
    logic [IDX_W-1:0] in_idx;
    logic             in_pin;
    logic [DT_W-1:0]  in_dt;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_pin = s_tdata[IDX_W];
    assign in_dt  = s_tdata[IDX_W+PIN_W+DT_W-1:IDX_W+PIN_W];

    // pipeline control
    logic r_s1_valid, r_out_valid;
    logic s_accept, s1_go;

    assign s1_go    = r_s1_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_s1_valid || s1_go;
    assign s_accept = s_tvalid && s_tready;

    // state memory: bit 7 of the control word is always set and not stored
    t_cw_store        mem [NUM_BUTTONS];
    t_cw_store        r_mem_q;
    logic [NUM_BUTTONS-1:0] r_valid;
    logic             r_rd_valid;

    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_pin;
    logic [DT_W-1:0]  r_s1_dt;

    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_idx;
    logic [CW_W-1:0]  r_fwd_cw;

    logic             s1_in_range;
    logic             s1_wr;
    logic [CW_W-1:0]  cw_cur, cw_nxt;

    assign s1_in_range = {1'b0, r_s1_idx} < (IDX_W+1)'(NUM_BUTTONS);
    assign s1_wr       = s1_go && s1_in_range;

    always_comb begin
        if (r_fwd_valid && r_fwd_idx == r_s1_idx) begin
            cw_cur = r_fwd_cw;
        end else if (r_rd_valid) begin
            cw_cur = {1'b1, r_mem_q};
        end else begin
            cw_cur = CW_UP_READY;
        end
    end

    mbd_cw_next u_cw_next (
        .i_cw       (cw_cur),
        .i_pin_high (r_s1_pin),
        .i_dt       (r_s1_dt),
        .i_hold     (r_holdoff),
        .o_cw       (cw_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mem_q <= mem[in_idx];
        end
        if (s1_wr) begin
            mem[r_s1_idx] <= cw_nxt[CW_W-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_rd_valid <= r_valid[in_idx];
            end
            if (s1_wr) begin
                r_valid[r_s1_idx] <= 1'b1;
            end
            if (s1_go) begin
                r_fwd_valid <= s1_in_range;
            end
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_idx <= in_idx;
            r_s1_pin <= in_pin;
            r_s1_dt  <= in_dt;
        end
        if (s1_go) begin
            r_fwd_idx <= r_s1_idx;
            r_fwd_cw  <= cw_nxt;
        end
    end

    // output register; the previous down flag is the down bit of the stored word
    logic r_out_down, r_out_press;
    logic [IDX_W-1:0] r_out_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_id    <= r_s1_idx;
            r_out_down  <= s1_in_range && cw_nxt[CW_DOWN_BIT];
            r_out_press <= s1_in_range && cw_cur[CW_DOWN_BIT] && !cw_nxt[CW_DOWN_BIT];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out_press, r_out_down, r_out_id};

endmodule

`default_nettype wire

>>> hdl/mbd_cw_next.sv
// mbd_cw_next: next control word of one button from its current word and one pin sample
// depends on mbd_pkg
`default_nettype none

module mbd_cw_next
    import mbd_pkg::*;
(
    input  wire logic [CW_W-1:0]   i_cw,
    input  wire logic              i_pin_high,
    input  wire logic [DT_W-1:0]   i_dt,
    input  wire logic [HOLD_W-1:0] i_hold,
    output logic      [CW_W-1:0]   o_cw
);

    logic [CW_W-1:0] sub;

    // 8-bit wrap, then clamped against the ready level below
    assign sub = i_cw - i_dt;

    always_comb begin
        if (i_dt > DT_RESYNC_MAX) begin
            o_cw = i_pin_high ? CW_UP_READY : CW_DOWN_READY;
        end else if (!i_pin_high) begin
            if (i_cw == CW_UP_READY) begin
                o_cw = CW_DOWN_READY | {2'b00, i_hold};
            end else if (i_cw > CW_DOWN_READY) begin
                o_cw = (sub < CW_DOWN_READY) ? CW_DOWN_READY : sub;
            end else begin
                o_cw = i_cw;
            end
        end else begin
            if (i_cw == CW_DOWN_READY) begin
                o_cw = CW_UP_READY | {2'b00, i_hold};
            end else if (i_cw > CW_UP_READY) begin
                o_cw = (sub < CW_UP_READY) ? CW_UP_READY : sub;
            end else begin
                o_cw = i_cw;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/mbd_checker.sv
// mbd_checker: port-level assertions for multi_button_debouncer, bound to the top level
// depends on mbd_pkg
`default_nettype none

module mbd_checker
    import mbd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                pready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a press means the button has just come up
    a_press_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[5] && m_tdata[4]))
        else $error("press reported while still down");

    // nothing is pending after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // with the pipeline empty, the result echoes the index of the transaction
    // once it has passed the update stage and the output register
    a_echo_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !m_tvalid && !$past(s_tvalid && s_tready)
            |=> ##1 m_tvalid && m_tdata[IDX_W-1:0] == $past(s_tdata[IDX_W-1:0], 2))
        else $error("result index does not match the sample");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pready   (pready)
);

`default_nettype wire
